FILE: rtl/core/rgbnv_pkg.sv
// ----------------------------------------------------------------------------
// rgbnv_pkg
// Shared types, constants and an arithmetic helper for the RGB to NV12 converter.
// ----------------------------------------------------------------------------
package rgbnv_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W  = 13;
  localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PIX_W  = 8;
  localparam int LOFF_W = 24;
  localparam int COFF_W = 25;

  localparam int LSUM_W = ROW_W + WSZ_W + 1;
  localparam int CSUM_W = WSZ_W + HSZ_W + 2;

  localparam int ADDR_W      = 3;
  localparam int APB_DATA_W  = 32;
  localparam int IN_TDATA_W  = 3 * PIX_W;
  localparam int OUT_FIELD_W = LOFF_W + PIX_W + COFF_W + 2 * PIX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(128);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(256);

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [WSZ_W-1:0] width;
    logic [HSZ_W-1:0] height;
  } frame_size_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [WSZ_W-1:0] width;
    logic [HSZ_W-1:0] height;
    logic             chroma;
    logic             last;
  } pix_stage_t;

  // floor(sum / 256) + bias, clamped to 0..255
  function automatic logic [PIX_W-1:0] scale_clamp(input logic signed [17:0] sum,
                                                   input logic signed [9:0]  bias);
    logic signed [9:0]  sh;
    logic signed [10:0] v;
    sh = 10'(sum >>> 8);
    v  = 11'(sh) + 11'(bias);
    if (v < 11'sd0) begin
      return '0;
    end else if (v > 11'sd255) begin
      return '1;
    end else begin
      return v[PIX_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/rgbnv_cfg.sv
// ----------------------------------------------------------------------------
// rgbnv_cfg
// APB register file for frame width and height, with size clamping.
// ----------------------------------------------------------------------------
module rgbnv_cfg import rgbnv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output frame_size_t           size
);

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic             wr_en;
  logic             reg_sel;

  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_sel    = cfg_paddr[ADDR_W-1];
  assign cfg_pready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  width_nxt  = cfg_pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: height_nxt = cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  cfg_prdata = APB_DATA_W'(width_r);
      REG_FRAME_HEIGHT: cfg_prdata = APB_DATA_W'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // zero is used as one, oversize as the maximum; cfg_prdata returns the raw value
  always_comb begin
    if (width_r == '0) begin
      size.width = WSZ_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      size.width = WSZ_W'(MAX_WIDTH);
    end else begin
      size.width = WSZ_W'(width_r);
    end
    if (height_r == '0) begin
      size.height = HSZ_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      size.height = HSZ_W'(MAX_HEIGHT);
    end else begin
      size.height = HSZ_W'(height_r);
    end
  end

endmodule

FILE: rtl/core/rgbnv_pos.sv
// ----------------------------------------------------------------------------
// rgbnv_pos
// Input register and raster position counters.
// ----------------------------------------------------------------------------
module rgbnv_pos import rgbnv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  frame_size_t           size,
  input  logic                  s2_ready,
  output logic                  s1_valid,
  output pix_stage_t            s1
);

  logic             s1_valid_r, s1_valid_nxt;
  pix_stage_t       s1_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             row_end;
  logic             last_row;

  assign in_tready = !s1_valid_r || s2_ready;
  assign accept    = in_tvalid && in_tready;
  assign row_end   = WSZ_W'(col_r) >= (size.width - WSZ_W'(1));
  assign last_row  = HSZ_W'(row_r) >= (size.height - HSZ_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.blue   <= in_tdata[PIX_W-1:0];
      s1_r.green  <= in_tdata[2*PIX_W-1:PIX_W];
      s1_r.red    <= in_tdata[3*PIX_W-1:2*PIX_W];
      s1_r.row    <= row_r;
      s1_r.col    <= col_r;
      s1_r.width  <= size.width;
      s1_r.height <= size.height;
      s1_r.chroma <= !row_r[0] && !col_r[0];
      s1_r.last   <= row_end && last_row;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

FILE: rtl/core/rgbnv_calc.sv
// ----------------------------------------------------------------------------
// rgbnv_calc
// Colour conversion, buffer offsets and the output register.
// ----------------------------------------------------------------------------
module rgbnv_calc import rgbnv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  pix_stage_t             s1,
  output logic                   s2_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic                     out_valid_r, out_valid_nxt;
  logic                     load;
  logic signed [17:0]       rs, gs, bs;
  logic signed [17:0]       y_sum, u_sum, v_sum;
  logic [LSUM_W-1:0]        luma_sum;
  logic [CSUM_W-1:0]        area, slot, chroma_sum;
  logic [LOFF_W-1:0]        loff_r;
  logic [PIX_W-1:0]         y_r, u_r, v_r;
  logic [COFF_W-1:0]        coff_r;
  logic                     cvalid_r;
  logic                     last_r;

  assign s2_ready = !out_valid_r || out_tready;
  assign load     = s1_valid && s2_ready;

  always_comb begin
    rs = 18'(s1.red);
    gs = 18'(s1.green);
    bs = 18'(s1.blue);
    y_sum = 18'sd66 * rs + 18'sd129 * gs + 18'sd25 * bs + 18'sd128;
    u_sum = 18'sd112 * bs - 18'sd38 * rs - 18'sd74 * gs + 18'sd128;
    v_sum = 18'sd112 * rs - 18'sd94 * gs - 18'sd18 * bs + 18'sd128;
    luma_sum   = LSUM_W'(s1.row) * LSUM_W'(s1.width) + LSUM_W'(s1.col);
    area       = CSUM_W'(s1.width) * CSUM_W'(s1.height);
    slot       = CSUM_W'(s1.row >> 1) * CSUM_W'(s1.width >> 1) + CSUM_W'(s1.col >> 1);
    chroma_sum = area + (slot << 1);
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      loff_r   <= LOFF_W'(luma_sum);
      y_r      <= scale_clamp(y_sum, 10'sd16);
      cvalid_r <= s1.chroma;
      coff_r   <= s1.chroma ? COFF_W'(chroma_sum) : '0;
      u_r      <= s1.chroma ? scale_clamp(u_sum, 10'sd128) : '0;
      v_r      <= s1.chroma ? scale_clamp(v_sum, 10'sd128) : '0;
      last_r   <= s1.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, v_r, u_r, coff_r, y_r, loff_r};
  assign out_tuser  = cvalid_r;
  assign out_tlast  = last_r;

endmodule

FILE: rtl/core/rgb_to_nv12_pixel_converter.sv
// Each pixel passes the input register in rgbnv_pos and the output register
// in rgbnv_calc. Throughput: one pixel per clock while out_tready is high; the
// stages hand over on a one-entry register each, so a new pixel is taken while
// a result waits for out_tready. Reset (synchronous, rst_n low): handshake and
// counters clear, frame width and height return to 128 and 256.
// ----------------------------------------------------------------------------
// rgb_to_nv12_pixel_converter
// BT.601 RGB to NV12 converter: per-pixel luma, even-site chroma and offsets.
// ----------------------------------------------------------------------------
module rgb_to_nv12_pixel_converter import rgbnv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // blue [7:0], green [15:8], red [23:16]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // luma_offset [23:0], luma_value [31:24], chroma_offset [56:32],
  // chroma_u [64:57], chroma_v [72:65], zero pad above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // chroma_valid
  output logic                   out_tuser,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [ADDR_W-1:0]      cfg_paddr,
  input  logic [APB_DATA_W-1:0]  cfg_pwdata,
  output logic [APB_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  frame_size_t size;
  pix_stage_t  s1;
  logic        s1_valid;
  logic        s2_ready;

  rgbnv_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .size        (size)
  );

  rgbnv_pos u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .size      (size),
    .s2_ready  (s2_ready),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  rgbnv_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s2_ready   (s2_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/core/rgbnv_checker.sv
// ----------------------------------------------------------------------------
// rgbnv_checker
// Port-level checks on the converter's result stream.
// ----------------------------------------------------------------------------
module rgbnv_checker import rgbnv_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result transaction changed while stalled");

  a_no_valid_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid straight after reset");

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[72:32] == '0)
    else $error("chroma fields not zero on odd site");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:24] >= 8'd16 && out_tdata[31:24] <= 8'd235)
    else $error("luma outside 16..235");

  a_origin_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23:0] == '0 |-> out_tuser)
    else $error("frame origin without chroma");

endmodule

bind rgb_to_nv12_pixel_converter rgbnv_checker u_checker (.*);

FILE: tb/nv12_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv12_pixel_checker
// Watches the pixel, result and register channels of the RGB to NV12
// converter, predicts luma, chroma, offsets and frame end for every pixel
// transaction, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module nv12_pixel_checker import rgbnv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [ADDR_W-1:0]      cfg_paddr,
  input  logic [APB_DATA_W-1:0]  cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     fail_count,
  output int                     pixels_pending,
  output int                     pixels_done,
  output int                     chroma_done,
  output int                     frames_done
);

  typedef struct {
    logic [LOFF_W-1:0] luma_offset;
    logic [PIX_W-1:0]  luma_value;
    logic              chroma_valid;
    logic [COFF_W-1:0] chroma_offset;
    logic [PIX_W-1:0]  chroma_u;
    logic [PIX_W-1:0]  chroma_v;
    logic              frame_last;
  } nv12_sample_t;

  localparam int LUMA_LSB = LOFF_W;
  localparam int COFF_LSB = LOFF_W + PIX_W;
  localparam int U_LSB    = COFF_LSB + COFF_W;
  localparam int V_LSB    = U_LSB + PIX_W;

  nv12_sample_t     expected_samples[$];
  nv12_sample_t     head;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      row_pos;
  int unsigned      col_pos;

  function automatic int unsigned bounded_size(input logic [CFG_W-1:0] v,
                                               input int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // floor(sum / 256) + bias, clamped to a byte
  function automatic logic [PIX_W-1:0] bt601_byte(input int sum, input int bias);
    int v;
    v = (sum >>> 8) + bias;
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[PIX_W-1:0];
  endfunction

  task automatic convert_pixel(input logic [IN_TDATA_W-1:0] pix);
    int              b;
    int              g;
    int              r;
    int unsigned     w;
    int unsigned     h;
    longint unsigned slot;
    bit              row_end;
    bit              last_row;
    nv12_sample_t    s;
    b = int'(pix[PIX_W-1:0]);
    g = int'(pix[2*PIX_W-1:PIX_W]);
    r = int'(pix[3*PIX_W-1:2*PIX_W]);
    w = bounded_size(width_reg, MAX_WIDTH);
    h = bounded_size(height_reg, MAX_HEIGHT);
    row_end  = col_pos >= w - 1;
    last_row = row_pos >= h - 1;
    s.luma_offset   = LOFF_W'(longint'(row_pos) * w + col_pos);
    s.luma_value    = bt601_byte(66 * r + 129 * g + 25 * b + 128, 16);
    s.chroma_valid  = (row_pos[0] == 1'b0) && (col_pos[0] == 1'b0);
    s.chroma_offset = '0;
    s.chroma_u      = '0;
    s.chroma_v      = '0;
    if (s.chroma_valid) begin
      slot = longint'(row_pos / 2) * (w / 2) + col_pos / 2;
      s.chroma_offset = COFF_W'(longint'(w) * h + 2 * slot);
      s.chroma_u      = bt601_byte(-38 * r - 74 * g + 112 * b + 128, 128);
      s.chroma_v      = bt601_byte(112 * r - 94 * g - 18 * b + 128, 128);
    end
    s.frame_last = row_end && last_row;
    expected_samples.insert(expected_samples.size(), s);
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_samples.delete();
      width_reg   = WIDTH_RST;
      height_reg  = HEIGHT_RST;
      row_pos     = 0;
      col_pos     = 0;
      pixels_done = 0;
      chroma_done = 0;
      frames_done = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t: result transaction with no pixel outstanding, expected none, got %h",
                     $time, out_tdata);
        end else begin
          head = expected_samples.pop_front();
          compare_field("luma_offset", 32'(head.luma_offset),
                        32'(out_tdata[LOFF_W-1:0]));
          compare_field("luma_value", 32'(head.luma_value),
                        32'(out_tdata[LUMA_LSB +: PIX_W]));
          compare_field("chroma_valid", 32'(head.chroma_valid), 32'(out_tuser));
          compare_field("chroma_offset", 32'(head.chroma_offset),
                        32'(out_tdata[COFF_LSB +: COFF_W]));
          compare_field("chroma_u", 32'(head.chroma_u),
                        32'(out_tdata[U_LSB +: PIX_W]));
          compare_field("chroma_v", 32'(head.chroma_v),
                        32'(out_tdata[V_LSB +: PIX_W]));
          compare_field("frame_last", 32'(head.frame_last), 32'(out_tlast));
          compare_field("tdata padding", '0,
                        32'(out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]));
          pixels_done++;
          if (head.chroma_valid) chroma_done++;
          if (head.frame_last) frames_done++;
        end
      end
      if (in_tvalid && in_tready) convert_pixel(in_tdata);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_FRAME_WIDTH) begin
          width_reg = cfg_pwdata[CFG_W-1:0];
        end else begin
          height_reg = cfg_pwdata[CFG_W-1:0];
        end
      end
    end
    pixels_pending <= expected_samples.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel transactions and frame size writes into the RGB to NV12
// converter with random idling on both streams; the checker beside the block
// predicts every result and this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench import rgbnv_pkg::*; ();

  localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]      cfg_paddr = '0;
  logic [APB_DATA_W-1:0]  cfg_pwdata = '0;
  logic [APB_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int fail_count;
  int pixels_pending;
  int pixels_done;
  int chroma_done;
  int frames_done;

  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;

  always #4 clk = ~clk;

  rgb_to_nv12_pixel_converter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  nv12_pixel_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pixels_pending(pixels_pending),
    .pixels_done(pixels_done), .chroma_done(chroma_done), .frames_done(frames_done)
  );

  // mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || !stalls_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {r, g, b};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_random_pixel();
    logic [PIX_W-1:0] ch[3];
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 7) == 0) ch[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else ch[i] = PIX_W'($urandom_range(0, 255));
    end
    push_pixel(ch[0], ch[1], ch[2]);
  endtask

  // hold the pixel stream until every outstanding result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [APB_DATA_W-1:0] random_size(input int common_max);
    logic [APB_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 1;
      2: v = MAX_WIDTH;
      3: v = $urandom_range(MAX_WIDTH + 1, 8191);
      default: v = $urandom_range(1, common_max);
    endcase
    // junk above the register width now and then
    if ($urandom_range(0, 3) == 0) v[APB_DATA_W-1:CFG_W] = (APB_DATA_W - CFG_W)'($urandom());
    return v;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // colour cube corners and a few mid tones at the reset frame size
    for (int i = 0; i < 8; i++)
      push_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, i[2] ? 8'hFF : 8'h00);
    push_pixel(8'd128, 8'd128, 8'd128);
    push_pixel(8'd1, 8'd2, 8'd3);
    push_pixel(8'd200, 8'd17, 8'd90);
    push_pixel(8'd7, 8'd250, 8'd33);
    drain();

    // odd width, two rows, shrunk under counters already past the new size
    write_reg(WIDTH_ADDR, 32'd3);
    write_reg(HEIGHT_ADDR, 32'd2);
    for (int i = 0; i < 8; i++) push_random_pixel();
    drain();

    // zero sizes behave as 1x1, every pixel ends a frame
    write_reg(WIDTH_ADDR, 32'd0);
    write_reg(HEIGHT_ADDR, 32'd0);
    for (int i = 0; i < 3; i++) push_random_pixel();
    drain();

    // oversize values saturate at the maximum frame size
    write_reg(WIDTH_ADDR, 32'hFFFF_FFFF);
    write_reg(HEIGHT_ADDR, 32'd5000);
    for (int i = 0; i < 3; i++) push_random_pixel();
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      gaps_on = ph[0];
      stalls_on <= ph[1];
      if ($urandom_range(0, 3) != 0) write_reg(WIDTH_ADDR, random_size(17));
      if ($urandom_range(0, 3) != 0) write_reg(HEIGHT_ADDR, random_size(9));
      for (int i = 0; i < 150; i++) begin
        push_random_pixel();
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    stalls_on <= 1'b0;
    drain();
    repeat (10) @(posedge clk);

    $display("Checked %0d pixel results, %0d with chroma, over %0d complete frames.",
             pixels_done, chroma_done, frames_done);
    $display("Small, zero, odd and oversize frames, resized between frames and mid-frame.");
    if (fail_count == 0 && pixels_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
